[hdl/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types, register indexes and the byte compare used by the wildcard
// byte pattern search core and its window cells.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Fixed field widths
  localparam int unsigned PAT_W       = 64;
  localparam int unsigned PAT_SLOTS   = PAT_W / 8;
  localparam int unsigned PAT_IDX_W   = $clog2(PAT_SLOTS);
  localparam int unsigned LEN_REG_W   = 4;
  localparam int unsigned OFS_W       = 32;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned CFG_IDX_W   = 8;

  // Parameter defaults
  localparam int unsigned DEF_PATTERN_BYTES = 8;
  localparam int unsigned DEF_OFFSET_BITS   = 32;

  // Pattern byte that matches any data byte ('?')
  localparam logic [7:0] WILDCARD_BYTE = 8'h3F;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_REGION_OFFSET  = CFG_IDX_W'(2);

  // Window control handed to every cell
  typedef struct packed {
    logic shift;  // a byte transfer happens this cycle
    logic clear;  // that byte closes the region
  } wbps_ctrl_t;

  // One pattern position: disabled, wildcard or equal byte counts as a hit
  function automatic logic byte_hit(input logic en, input logic [7:0] pat,
                                    input logic [7:0] data);
    return !en || (pat == WILDCARD_BYTE) || (pat == data);
  endfunction

endpackage

[hdl/wbps_cell.sv]
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds one earlier data byte, passes it to the next cell on
// every byte transfer, and compares it against its aligned pattern byte.
// ----------------------------------------------------------------------------
module wbps_cell
  import wbps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wbps_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_i,
  input  logic       en_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q, byte_d;

  // Shift in the neighbor's byte, drop everything at region end
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = byte_hit(en_i, pat_i, byte_q);

endmodule

[hdl/wildcard_byte_pattern_search_core.sv]
// Latency: a region's result is registered and shows on the cycle after its
// last byte transfer; other bytes give no result.
// Throughput: one byte per cycle, set by the window cell chain shifting once
// per transfer; input stalls only while a result waits on the output.
// Reset: asynchronous, clears window, counters, match state and registers
// (pattern length resets to 1); no clearing pass is needed.
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_core
// Finds the first match of a 1..PATTERN_BYTES byte pattern with '?' wildcards
// in a byte stream and reports found flag and offset at the region end.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_core
  import wbps_pkg::*;
#(
  parameter int unsigned PATTERN_BYTES = DEF_PATTERN_BYTES,
  parameter int unsigned OFFSET_BITS   = DEF_OFFSET_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PAT_W-1:0]     cfg_data_i,
  // byte stream
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [OFS_W-1:0]     match_offset_o
);

  localparam int unsigned LEN_W    = $clog2(PATTERN_BYTES + 1);
  localparam int unsigned CELLS    = PATTERN_BYTES - 1;
  localparam int unsigned OFS_KEEP = (OFFSET_BITS < OFS_W) ? OFFSET_BITS : OFS_W;
  localparam logic [OFS_W-1:0] OFS_MASK = {OFS_W{1'b1}} >> (OFS_W - OFS_KEEP);

  // Configuration registers
  logic [PAT_W-1:0]     pattern_q;
  logic [LEN_REG_W-1:0] length_q;
  logic [OFS_W-1:0]     region_ofs_q;

  // Region state
  logic [POS_W-1:0] pos_q, pos_d;
  logic             hit_seen_q, hit_seen_d;
  logic [POS_W-1:0] hit_start_q, hit_start_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [OFS_W-1:0] ofs_q, ofs_d;

  logic       in_xfer;
  logic       cfg_xfer;
  wbps_ctrl_t ctrl;

  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W-1:0]     len_m1;
  logic [7:0]           pat_bytes [PAT_SLOTS];
  logic [7:0]           pat_al    [PATTERN_BYTES];
  logic                 pat_en    [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] hits;
  logic                 match_now;
  logic [POS_W-1:0]     start_now;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign ctrl.shift  = in_xfer;
  assign ctrl.clear  = last_byte_i;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q    <= '0;
      length_q     <= LEN_REG_W'(1);
      region_ofs_q <= '0;
    end else if (cfg_xfer) begin
      if (cfg_index_i == REG_PATTERN_WORD) begin
        pattern_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_PATTERN_LENGTH) begin
        length_q <= cfg_data_i[LEN_REG_W-1:0];
      end
      if (cfg_index_i == REG_REGION_OFFSET) begin
        region_ofs_q <= cfg_data_i[OFS_W-1:0];
      end
    end
  end

  // Clamp pattern length to 1..PATTERN_BYTES
  always_comb begin
    if (length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(length_q) > PATTERN_BYTES) begin
      len_eff = LEN_W'(PATTERN_BYTES);
    end else begin
      len_eff = LEN_W'(length_q);
    end
    len_m1 = len_eff - LEN_W'(1);
  end

  // Align pattern bytes to distance back from the current byte
  always_comb begin
    for (int s = 0; s < PAT_SLOTS; s++) begin
      pat_bytes[s] = pattern_q[8*s +: 8];
    end
    for (int d = 0; d < PATTERN_BYTES; d++) begin
      pat_en[d] = (LEN_W'(d) <= len_m1);
      pat_al[d] = pat_bytes[PAT_IDX_W'(len_m1) - PAT_IDX_W'(d)];
    end
  end

  // Current byte compare sits in front of the chain
  assign hits[0] = byte_hit(pat_en[0], pat_al[0], data_byte_i);

  // Window cell chain, cell k holds the byte k+1 transfers back
  if (CELLS > 0) begin : g_chain
    logic [7:0] win [CELLS];
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
      wbps_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .byte_i ((k == 0) ? data_byte_i : win[(k == 0) ? 0 : k-1]),
        .pat_i  (pat_al[k+1]),
        .en_i   (pat_en[k+1]),
        .byte_o (win[k]),
        .hit_o  (hits[k+1])
      );
    end
  end

  // Match only once enough bytes of the region have arrived
  assign match_now = (&hits) && !hit_seen_q && (pos_q >= POS_W'(len_m1));
  assign start_now = pos_q - POS_W'(len_m1);

  // Advance region state and load result on the closing byte
  always_comb begin
    pos_d       = pos_q;
    hit_seen_d  = hit_seen_q;
    hit_start_d = hit_start_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    ofs_d       = ofs_q;
    if (in_xfer) begin
      if (match_now) begin
        hit_seen_d  = 1'b1;
        hit_start_d = start_now;
      end
      if (pos_q != POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end
      if (last_byte_i) begin
        out_valid_d = 1'b1;
        found_d     = hit_seen_d;
        ofs_d       = hit_seen_d ? ((region_ofs_q + hit_start_d) & OFS_MASK) : '0;
        pos_d       = '0;
        hit_seen_d  = 1'b0;
        hit_start_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hit_seen_q  <= 1'b0;
      hit_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hit_seen_q  <= hit_seen_d;
      hit_start_q <= hit_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    ofs_q   <= ofs_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = ofs_q;

`ifndef SYNTHESIS
  a_no_hit_zero_ofs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_offset_o == '0)
    else $error("match offset nonzero without a hit");

  a_last_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> out_valid_q)
    else $error("region end produced no result");

  a_region_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_byte_i |=> pos_q == '0 && !hit_seen_q)
    else $error("region state not cleared");

  a_first_hit_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_seen_q && !(in_xfer && last_byte_i) |=> hit_seen_q && $stable(hit_start_q))
    else $error("first match lost inside region");
`endif

endmodule
